>>> design/mesd_pkg.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder package
// Shared constants, codes, the classified beat type and the status length
// lookup used by the front and back halves of the decoder.
// ----------------------------------------------------------------------------
package mesd_pkg;

  localparam int TICK_WIDTH      = 48;
  localparam int MAX_DELTA_BYTES = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam int DELTA_W   = 7 * MAX_DELTA_BYTES;
  localparam int SUM_W     = (TICK_WIDTH > DELTA_W) ? TICK_WIDTH : DELTA_W;
  localparam int TEMPO_BYTES = 3;
  localparam int CNT_MAX   = (MAX_DELTA_BYTES > TEMPO_BYTES) ? MAX_DELTA_BYTES : TEMPO_BYTES;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_END_OPCODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_OPCODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TEMPO = 2'd2;

  localparam logic [7:0]  END_OPCODE_RST    = 8'd255;
  localparam logic [7:0]  TEMPO_OPCODE_RST  = 8'd81;
  localparam logic [23:0] DEFAULT_TEMPO_RST = 24'd500000;

  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY       = 4'hA;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_BEND       = 4'hE;

  typedef enum logic [3:0] {
    EK_NOTE_OFF   = 4'd0,
    EK_NOTE_ON    = 4'd1,
    EK_POLY       = 4'd2,
    EK_CONTROL    = 4'd3,
    EK_PROGRAM    = 4'd4,
    EK_CHAN_PRESS = 4'd5,
    EK_BEND       = 4'd6,
    EK_TEMPO      = 4'd7,
    EK_END        = 4'd8,
    EK_ERROR      = 4'd9
  } event_kind_t;

  typedef enum logic [2:0] {
    EC_NONE       = 3'd0,
    EC_LONG_DELTA = 3'd1,
    EC_ZERO_TEMPO = 3'd2,
    EC_NO_STATUS  = 3'd3,
    EC_BAD_STATUS = 3'd4
  } err_cause_t;

  typedef struct packed {
    logic       rewind;
    logic [7:0] data_byte;
    logic       is_end;
    logic       is_tempo;
    logic [1:0] msg_len;
  } cls_t;

  function automatic logic [1:0] data_len(input logic [7:0] status);
    logic [1:0] n;
    case (status[7:4]) inside
      ST_PROGRAM, ST_CHAN_PRESS: n = 2'd1;
      ST_NOTE_OFF, ST_NOTE_ON, ST_POLY, ST_CONTROL, ST_BEND: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> design/mesd_if.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder channel interfaces
// Valid/ready channels for the input byte stream and the decoded events.
// ----------------------------------------------------------------------------
interface mesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       rewind;

  modport source (output valid, output stream_byte, output rewind, input ready);
  modport sink (input valid, input stream_byte, input rewind, output ready);
endinterface

interface mesd_out_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      event_kind;
  logic [3:0]                      channel;
  logic [7:0]                      first_data;
  logic [7:0]                      second_data;
  logic [15:0]                     bend_value;
  logic [23:0]                     tempo_value;
  logic [mesd_pkg::TICK_WIDTH-1:0] event_tick;
  logic [2:0]                      error_cause;

  modport source (output valid, output event_kind, output channel, output first_data,
                  output second_data, output bend_value, output tempo_value,
                  output event_tick, output error_cause, input ready);
  modport sink (input valid, input event_kind, input channel, input first_data,
                input second_data, input bend_value, input tempo_value,
                input event_tick, input error_cause, output ready);
endinterface

>>> design/mesd_front.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder front end
// Accepts input beats while the queue has room and tags each byte with its
// opcode matches and channel message length.
// ----------------------------------------------------------------------------
module mesd_front (
  mesd_in_if.sink         in_bus,
  input  logic [7:0]      end_opcode,
  input  logic [7:0]      tempo_opcode,
  input  logic            queue_full,
  output logic            push,
  output mesd_pkg::cls_t  push_data
);

  assign in_bus.ready = !queue_full;
  assign push         = in_bus.valid && !queue_full;

  always_comb begin
    push_data.rewind    = in_bus.rewind;
    push_data.data_byte = in_bus.stream_byte;
    push_data.is_end    = (in_bus.stream_byte == end_opcode);
    push_data.is_tempo  = (in_bus.stream_byte == tempo_opcode);
    push_data.msg_len   = mesd_pkg::data_len(in_bus.stream_byte);
  end

endmodule

>>> design/mesd_queue.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder classification queue
// Short FIFO that decouples the front end from the parser.
// ----------------------------------------------------------------------------
module mesd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mesd_pkg::cls_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output mesd_pkg::cls_t  head
);

  mesd_pkg::cls_t                   entries_r [mesd_pkg::QUEUE_DEPTH];
  logic [mesd_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [mesd_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [mesd_pkg::QCNT_W-1:0]      count_r;
  logic [mesd_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [mesd_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [mesd_pkg::QCNT_W-1:0]      count_nxt;

  assign full       = (count_r == mesd_pkg::QCNT_W'(mesd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mesd_pkg::QPTR_W'(mesd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mesd_pkg::QPTR_W'(mesd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/mesd_back.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder back end
// Parser state machine: delta accumulation, tempo assembly, running status
// and channel message decoding, with a registered result beat.
// ----------------------------------------------------------------------------
module mesd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [23:0]     default_tempo,
  input  logic            head_valid,
  input  mesd_pkg::cls_t  head,
  output logic            pop,
  mesd_out_if.source      out_bus
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_OPCODE,
    PH_TEMPO,
    PH_DATA1,
    PH_DATA2,
    PH_DONE
  } phase_t;

  localparam int TW = mesd_pkg::TICK_WIDTH;
  localparam int DW = mesd_pkg::DELTA_W;
  localparam int CW = mesd_pkg::CNT_W;

  phase_t           phase_r, phase_nxt;
  logic [DW-1:0]    delta_r, delta_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [7:0]       running_r, running_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [23:0]      tempo_r, tempo_nxt;
  logic             stuck_r, stuck_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [3:0]       kind_r, kind_nxt;
  logic [3:0]       chan_r, chan_nxt;
  logic [7:0]       d1_r, d1_nxt;
  logic [7:0]       d2_r, d2_nxt;
  logic [15:0]      bend_r, bend_nxt;
  logic [23:0]      tval_r, tval_nxt;
  logic [TW-1:0]    etick_r, etick_nxt;
  logic [2:0]       cause_r, cause_nxt;

  logic [7:0]       b;
  logic [DW+6:0]    delta_shift;
  logic [DW-1:0]    delta_step;
  logic [CW-1:0]    cnt_inc;
  logic [TW-1:0]    tick_sum;
  logic [23:0]      tempo_step;
  logic             emit;
  logic             ch_emit;
  logic [7:0]       ch_status;
  logic [7:0]       ch_d1;
  logic [7:0]       ch_d2;
  logic [3:0]       ch_kind;
  logic [3:0]       ev_kind;
  logic [23:0]      ev_tempo;
  logic [2:0]       ev_cause;

  assign pop         = head_valid && (!out_valid_r || out_bus.ready);
  assign b           = head.data_byte;
  assign delta_shift = {delta_r, b[6:0]};
  assign delta_step  = delta_shift[DW-1:0];
  assign cnt_inc     = cnt_r + 1'b1;
  assign tick_sum    = TW'(mesd_pkg::SUM_W'(tick_r) + mesd_pkg::SUM_W'(delta_step));
  assign tempo_step  = {tempo_r[15:0], b};
  assign ch_kind     = ch_status[7:4] - 4'd8;

  always_comb begin
    phase_nxt     = phase_r;
    delta_nxt     = delta_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    running_nxt   = running_r;
    status_nxt    = status_r;
    held_nxt      = held_r;
    tempo_nxt     = tempo_r;
    stuck_nxt     = stuck_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    emit          = 1'b0;
    ch_emit       = 1'b0;
    ch_status     = status_r;
    ch_d1         = held_r;
    ch_d2         = '0;
    ev_kind       = mesd_pkg::EK_ERROR;
    ev_tempo      = '0;
    ev_cause      = mesd_pkg::EC_NONE;

    if (pop) begin
      if (head.rewind) begin
        phase_nxt   = PH_DELTA;
        delta_nxt   = '0;
        cnt_nxt     = '0;
        tick_nxt    = '0;
        running_nxt = '0;
        status_nxt  = '0;
        held_nxt    = '0;
        tempo_nxt   = default_tempo;
        stuck_nxt   = 1'b0;
      end else if (!stuck_r && phase_r != PH_DONE) begin
        case (phase_r)
          PH_DELTA: begin
            if (!b[7]) begin
              tick_nxt  = tick_sum;
              delta_nxt = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_OPCODE;
            end else begin
              delta_nxt = delta_step;
              cnt_nxt   = cnt_inc;
              if (cnt_inc >= CW'(mesd_pkg::MAX_DELTA_BYTES)) begin
                emit      = 1'b1;
                stuck_nxt = 1'b1;
                ev_kind   = mesd_pkg::EK_ERROR;
                ev_cause  = mesd_pkg::EC_LONG_DELTA;
              end
            end
          end
          PH_OPCODE: begin
            if (head.is_end) begin
              phase_nxt = PH_DONE;
              emit      = 1'b1;
              ev_kind   = mesd_pkg::EK_END;
            end else if (head.is_tempo) begin
              phase_nxt = PH_TEMPO;
              cnt_nxt   = '0;
              tempo_nxt = '0;
            end else if (b[7]) begin
              if (head.msg_len == 2'd0) begin
                emit      = 1'b1;
                stuck_nxt = 1'b1;
                ev_kind   = mesd_pkg::EK_ERROR;
                ev_cause  = mesd_pkg::EC_BAD_STATUS;
              end else begin
                status_nxt  = b;
                running_nxt = b;
                phase_nxt   = PH_DATA1;
              end
            end else if (running_r == '0) begin
              emit      = 1'b1;
              stuck_nxt = 1'b1;
              ev_kind   = mesd_pkg::EK_ERROR;
              ev_cause  = mesd_pkg::EC_NO_STATUS;
            end else begin
              status_nxt = running_r;
              held_nxt   = b;
              if (mesd_pkg::data_len(running_r) == 2'd1) begin
                ch_emit   = 1'b1;
                ch_status = running_r;
                ch_d1     = b;
                phase_nxt = PH_DELTA;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
          end
          PH_TEMPO: begin
            tempo_nxt = tempo_step;
            cnt_nxt   = cnt_inc;
            if (cnt_inc >= CW'(mesd_pkg::TEMPO_BYTES)) begin
              cnt_nxt = '0;
              emit    = 1'b1;
              if (tempo_step == '0) begin
                stuck_nxt = 1'b1;
                ev_kind   = mesd_pkg::EK_ERROR;
                ev_cause  = mesd_pkg::EC_ZERO_TEMPO;
              end else begin
                running_nxt = '0;
                phase_nxt   = PH_DELTA;
                ev_kind     = mesd_pkg::EK_TEMPO;
                ev_tempo    = tempo_step;
              end
            end
          end
          PH_DATA1: begin
            held_nxt = b;
            if (mesd_pkg::data_len(status_r) == 2'd1) begin
              ch_emit   = 1'b1;
              ch_d1     = b;
              phase_nxt = PH_DELTA;
            end else begin
              phase_nxt = PH_DATA2;
            end
          end
          PH_DATA2: begin
            ch_emit   = 1'b1;
            ch_d2     = b;
            phase_nxt = PH_DELTA;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end

    kind_nxt  = kind_r;
    chan_nxt  = chan_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    bend_nxt  = bend_r;
    tval_nxt  = tval_r;
    etick_nxt = etick_r;
    cause_nxt = cause_r;
    if (ch_emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = ch_kind;
      chan_nxt      = ch_status[3:0];
      d1_nxt        = ch_d1;
      d2_nxt        = ch_d2;
      bend_nxt      = (ch_kind == mesd_pkg::EK_BEND) ?
                      ({1'b0, ch_d2, 7'b0} | {8'b0, ch_d1}) : '0;
      tval_nxt      = '0;
      etick_nxt     = tick_r;
      cause_nxt     = mesd_pkg::EC_NONE;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = ev_kind;
      chan_nxt      = '0;
      d1_nxt        = '0;
      d2_nxt        = '0;
      bend_nxt      = '0;
      tval_nxt      = ev_tempo;
      etick_nxt     = tick_r;
      cause_nxt     = ev_cause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DELTA;
      delta_r     <= '0;
      cnt_r       <= '0;
      tick_r      <= '0;
      running_r   <= '0;
      status_r    <= '0;
      held_r      <= '0;
      tempo_r     <= mesd_pkg::DEFAULT_TEMPO_RST;
      stuck_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      delta_r     <= delta_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      status_r    <= status_nxt;
      held_r      <= held_nxt;
      tempo_r     <= tempo_nxt;
      stuck_r     <= stuck_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r  <= kind_nxt;
    chan_r  <= chan_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    bend_r  <= bend_nxt;
    tval_r  <= tval_nxt;
    etick_r <= etick_nxt;
    cause_r <= cause_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.event_kind  = kind_r;
  assign out_bus.channel     = chan_r;
  assign out_bus.first_data  = d1_r;
  assign out_bus.second_data = d2_r;
  assign out_bus.bend_value  = bend_r;
  assign out_bus.tempo_value = tval_r;
  assign out_bus.event_tick  = etick_r;
  assign out_bus.error_cause = cause_r;

  a_quiet_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.rewind && (stuck_r || phase_r == PH_DONE)) |-> !(emit || ch_emit))
    else $error("Result produced while the parser is halted.");

  a_delta_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DELTA && !stuck_r) |-> (cnt_r < CW'(mesd_pkg::MAX_DELTA_BYTES)))
    else $error("Delta byte count reached its limit without an error.");

  a_cause_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((kind_r == mesd_pkg::EK_ERROR) == (cause_r != mesd_pkg::EC_NONE)))
    else $error("Error cause disagrees with event kind.");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (stuck_r && !(pop && head.rewind)) |=> stuck_r)
    else $error("Error state left without a rewind.");

endmodule

>>> design/midi_event_stream_decoder.sv
// ----------------------------------------------------------------------------
// MIDI event stream decoder
// Accepts one input beat per cycle while the queue has room. The byte that
// completes a result is written to the queue when accepted, and the parser
// loads the output register when it pops that byte. Sustained throughput is
// one byte per cycle while the output is not held by back-pressure. A
// synchronous active-low reset restores the configuration registers and
// parser state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_event_stream_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  mesd_in_if.sink                            in_bus,
  mesd_out_if.source                         out_bus,
  input  logic                               cfg_we,
  input  logic [mesd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mesd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [7:0]      cfg_end_opcode_r;
  logic [7:0]      cfg_tempo_opcode_r;
  logic [23:0]     cfg_default_tempo_r;

  logic            push;
  mesd_pkg::cls_t  push_data;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  mesd_pkg::cls_t  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_end_opcode_r    <= mesd_pkg::END_OPCODE_RST;
      cfg_tempo_opcode_r  <= mesd_pkg::TEMPO_OPCODE_RST;
      cfg_default_tempo_r <= mesd_pkg::DEFAULT_TEMPO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mesd_pkg::CFG_END_OPCODE:    cfg_end_opcode_r    <= cfg_wdata[7:0];
        mesd_pkg::CFG_TEMPO_OPCODE:  cfg_tempo_opcode_r  <= cfg_wdata[7:0];
        mesd_pkg::CFG_DEFAULT_TEMPO: cfg_default_tempo_r <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  mesd_front u_front (
    .in_bus       (in_bus),
    .end_opcode   (cfg_end_opcode_r),
    .tempo_opcode (cfg_tempo_opcode_r),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  mesd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  mesd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .default_tempo (cfg_default_tempo_r),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_bus       (out_bus)
  );

endmodule
